>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the slot allocator.
// Self-contained; included by the file that binds the checker to the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed (same-cycle rule)");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed (next-cycle rule)");

`endif

>>> hw/rtl/lssa_pkg.sv
// Package of the linear-scan slot allocator: types, codes and defaults.
// No dependencies; imported by every module of the block but lssa_slot_mem.
package lssa_pkg;

    // Default values of the top-level parameters.
    localparam int DEVICES_DEF  = 4;
    localparam int SLOTS_DEF    = 32;
    localparam int OP_BITS_DEF  = 16;

    // Fixed field widths of the request and result beats.
    localparam int DEV_FIELD_W  = 2;
    localparam int SLOT_FIELD_W = 5;
    localparam int STATUS_W     = 2;

    // Configuration register file layout.
    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int MASK_W       = 4;
    localparam int CNT_CFG_W    = 6;
    localparam int CFG_DEVS     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_DEV0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_DEV1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_DEV2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_DEV3   = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_GRANT     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_POOL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd2;

    // Configuration as seen by the allocation controller.
    typedef struct packed {
        logic [MASK_W-1:0]                   present_mask;
        logic [CFG_DEVS-1:0][CNT_CFG_W-1:0]  slots;
    } t_cfg;

endpackage

>>> hw/rtl/lssa_cfg_regs.sv
// APB-style configuration registers of the slot allocator.
// Depends on lssa_pkg for the register layout and the t_cfg type.
module lssa_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lssa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lssa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [lssa_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output lssa_pkg::t_cfg                    o_cfg
);
    import lssa_pkg::*;

    logic [CFG_IDX_W-1:0] w_idx;
    logic                 w_wr;
    t_cfg                 r_cfg;

    assign w_idx  = paddr[CFG_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PRESENT_MASK: r_cfg.present_mask <= pwdata[MASK_W-1:0];
                REG_SLOTS_DEV0:   r_cfg.slots[0]     <= pwdata[CNT_CFG_W-1:0];
                REG_SLOTS_DEV1:   r_cfg.slots[1]     <= pwdata[CNT_CFG_W-1:0];
                REG_SLOTS_DEV2:   r_cfg.slots[2]     <= pwdata[CNT_CFG_W-1:0];
                REG_SLOTS_DEV3:   r_cfg.slots[3]     <= pwdata[CNT_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_PRESENT_MASK: prdata = CFG_DATA_W'(r_cfg.present_mask);
            REG_SLOTS_DEV0:   prdata = CFG_DATA_W'(r_cfg.slots[0]);
            REG_SLOTS_DEV1:   prdata = CFG_DATA_W'(r_cfg.slots[1]);
            REG_SLOTS_DEV2:   prdata = CFG_DATA_W'(r_cfg.slots[2]);
            REG_SLOTS_DEV3:   prdata = CFG_DATA_W'(r_cfg.slots[3]);
            default:          prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/lssa_slot_mem.sv
// Single-port free-time memory of the slot allocator with a registered read port.
// Depends on nothing but its parameters.
module lssa_slot_mem #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 17,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

endmodule

>>> hw/rtl/lssa_ctrl.sv
// Allocation controller: clearing sweeps, minimum scan and write-back.
// Depends on lssa_pkg; drives the port of lssa_slot_mem.
module lssa_ctrl #(
    parameter int DEVICES       = lssa_pkg::DEVICES_DEF,
    parameter int SLOTS         = lssa_pkg::SLOTS_DEF,
    parameter int OP_INDEX_BITS = lssa_pkg::OP_BITS_DEF,
    parameter int ADDR_W        = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lssa_pkg::t_cfg                      i_cfg,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_new_pass,
    input  logic [lssa_pkg::DEV_FIELD_W-1:0]    i_device,
    input  logic [OP_INDEX_BITS-1:0]            i_def_op,
    input  logic [OP_INDEX_BITS-1:0]            i_end_op,
    output logic                                o_done,
    output logic [lssa_pkg::STATUS_W-1:0]       o_status,
    output logic [lssa_pkg::SLOT_FIELD_W-1:0]   o_slot,
    output logic                                o_mem_we,
    output logic [ADDR_W-1:0]                   o_mem_addr,
    output logic [OP_INDEX_BITS:0]              o_mem_wdata,
    input  logic [OP_INDEX_BITS:0]              i_mem_rdata
);
    import lssa_pkg::*;

    localparam int TIME_W = OP_INDEX_BITS + 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [DEV_W-1:0]  DEV_LAST  = DEV_W'(DEVICES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]               r_state,     n_state;
    logic                     r_clr_all,   n_clr_all;
    logic [DEV_W-1:0]         r_cd,        n_cd;
    logic [SLOT_W-1:0]        r_ci,        n_ci;
    logic [DEV_FIELD_W-1:0]   r_dev,       n_dev;
    logic [OP_INDEX_BITS-1:0] r_first,     n_first;
    logic [OP_INDEX_BITS-1:0] r_last,      n_last;
    logic [CNT_W-1:0]         r_cnt,       n_cnt;
    logic [SLOT_W-1:0]        r_idx,       n_idx;
    logic                     r_rd_vld,    n_rd_vld;
    logic [SLOT_W-1:0]        r_rd_idx,    n_rd_idx;
    logic [SLOT_W-1:0]        r_best_idx,  n_best_idx;
    logic [TIME_W-1:0]        r_best_time, n_best_time;
    logic                     r_done,      n_done;
    logic [STATUS_W-1:0]      r_status,    n_status;
    logic [SLOT_FIELD_W-1:0]  r_slot,      n_slot;
    logic                     w_clr_wr;
    logic [CNT_W-1:0]         w_req_cnt;

    // A device has a pool when it exists in this build and its mask bit is set.
    function automatic logic f_present(input logic [MASK_W-1:0] mask,
                                       input int unsigned dev);
        logic bit_set;
        bit_set = mask[dev[1:0]];
        return (dev < DEVICES) && (dev < CFG_DEVS) && bit_set;
    endfunction

    // Configured slot count of a device, limited to the pool depth.
    function automatic logic [CNT_W-1:0] f_count(input t_cfg cfg, input int unsigned dev);
        logic [CNT_CFG_W-1:0] raw;
        raw = cfg.slots[dev[1:0]];
        if (dev >= CFG_DEVS) begin
            return '0;
        end
        if (int'(raw) > SLOTS) begin
            return CNT_W'(SLOTS);
        end
        return CNT_W'(raw);
    endfunction

    // Memory address of slot i of device d.
    function automatic logic [ADDR_W-1:0] f_addr(input int unsigned d, input int unsigned i);
        return ADDR_W'(d * SLOTS + i);
    endfunction

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_slot   = r_slot;

    assign w_clr_wr  = r_clr_all || (f_present(i_cfg.present_mask, r_cd)
                        && (CNT_W'(r_ci) < f_count(i_cfg, r_cd)));
    assign w_req_cnt = f_count(i_cfg, r_dev);

    // Next-state logic of the sequencer and the running minimum.
    always_comb begin
        n_state     = r_state;
        n_clr_all   = r_clr_all;
        n_cd        = r_cd;
        n_ci        = r_ci;
        n_dev       = r_dev;
        n_first     = r_first;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_best_idx  = r_best_idx;
        n_best_time = r_best_time;
        n_done      = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        o_mem_we    = 1'b0;
        o_mem_addr  = f_addr(r_dev, r_idx);
        o_mem_wdata = '0;

        // Compare the entry read in the previous cycle; the first one seeds the minimum.
        if (r_rd_vld) begin
            if ((r_rd_idx == '0) || (i_mem_rdata < r_best_time)) begin
                n_best_time = i_mem_rdata;
                n_best_idx  = r_rd_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_dev   = i_device;
                    n_first = i_def_op;
                    n_last  = i_end_op;
                    n_cd    = '0;
                    n_ci    = '0;
                    n_state = i_new_pass ? S_CLEAR : S_CHECK;
                end
            end
            S_CLEAR: begin
                // One entry per cycle; a device is left as soon as its pool is done.
                o_mem_addr = f_addr(r_cd, r_ci);
                o_mem_we   = w_clr_wr;
                if (w_clr_wr && (r_ci != SLOT_LAST)) begin
                    n_ci = r_ci + SLOT_W'(1);
                end else begin
                    n_ci = '0;
                    if (r_cd == DEV_LAST) begin
                        n_cd      = '0;
                        n_clr_all = 1'b0;
                        n_state   = r_clr_all ? S_IDLE : S_CHECK;
                    end else begin
                        n_cd = r_cd + DEV_W'(1);
                    end
                end
            end
            S_CHECK: begin
                if (!f_present(i_cfg.present_mask, r_dev)) begin
                    n_done   = 1'b1;
                    n_status = STAT_NO_POOL;
                    n_slot   = '0;
                    n_state  = S_IDLE;
                end else if (w_req_cnt == '0) begin
                    n_done   = 1'b1;
                    n_status = STAT_EXHAUSTED;
                    n_slot   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_cnt   = w_req_cnt;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue one read per cycle over the device's pool.
                o_mem_addr = f_addr(r_dev, r_idx);
                n_rd_vld   = 1'b1;
                n_rd_idx   = r_idx;
                if ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_WAIT: begin
                // The last read returns in this cycle and is folded in above.
                n_state = S_FIN;
            end
            S_FIN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_best_time > TIME_W'(r_first)) begin
                    n_status = STAT_EXHAUSTED;
                    n_slot   = '0;
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_addr  = f_addr(r_dev, r_best_idx);
                    o_mem_wdata = TIME_W'(r_last) + TIME_W'(1);
                    n_status    = STAT_GRANT;
                    n_slot      = SLOT_FIELD_W'(r_best_idx);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the sweep that zeroes the whole memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_all <= 1'b1;
            r_cd      <= '0;
            r_ci      <= '0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_all <= n_clr_all;
            r_cd      <= n_cd;
            r_ci      <= n_ci;
            r_rd_vld  <= n_rd_vld;
            r_done    <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_dev       <= n_dev;
        r_first     <= n_first;
        r_last      <= n_last;
        r_cnt       <= n_cnt;
        r_idx       <= n_idx;
        r_rd_idx    <= n_rd_idx;
        r_best_idx  <= n_best_idx;
        r_best_time <= n_best_time;
        r_status    <= n_status;
        r_slot      <= n_slot;
    end

endmodule

>>> hw/rtl/linear_scan_slot_allocator.sv
// Top level of the linear-scan slot allocator.
// Depends on lssa_pkg, lssa_cfg_regs, lssa_ctrl and lssa_slot_mem.
//
//   Channel   Handshake                        Beat contents
//   request   start & !busy                    i_new_pass, i_device, i_def_op, i_end_op
//   result    o_done (one cycle, no stall)     o_status, o_slot
//   config    psel & penable & pwrite (APB)    paddr, pwdata; prdata on reads
//
// A request whose device has no pool, or an empty pool, is refused with no memory access.
// Any other request does one memory read per slot through the single port, then
// one write-back when a slot is granted.
// A new-pass beat first sweeps the present pools, one entry per cycle, with an
// idle step for each device whose pool is absent or smaller than SLOTS.
// After reset the whole memory (DEVICES*SLOTS entries, 128 by default) is
// cleared one entry per cycle while busy is high; config writes are taken.
module linear_scan_slot_allocator #(
    parameter int DEVICES       = lssa_pkg::DEVICES_DEF,
    parameter int SLOTS         = lssa_pkg::SLOTS_DEF,
    parameter int OP_INDEX_BITS = lssa_pkg::OP_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_new_pass,
    input  logic [lssa_pkg::DEV_FIELD_W-1:0]    i_device,
    input  logic [OP_INDEX_BITS-1:0]            i_def_op,
    input  logic [OP_INDEX_BITS-1:0]            i_end_op,
    output logic                                o_done,
    output logic [lssa_pkg::STATUS_W-1:0]       o_status,
    output logic [lssa_pkg::SLOT_FIELD_W-1:0]   o_slot,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lssa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lssa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lssa_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lssa_pkg::*;

    localparam int DEPTH  = DEVICES * SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TIME_W = OP_INDEX_BITS + 1;

    t_cfg              w_cfg;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_addr;
    logic [TIME_W-1:0] w_mem_wdata;
    logic [TIME_W-1:0] w_mem_rdata;

    // Configuration registers.
    lssa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer for clearing, scanning and write-back.
    lssa_ctrl #(
        .DEVICES       (DEVICES),
        .SLOTS         (SLOTS),
        .OP_INDEX_BITS (OP_INDEX_BITS),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_start     (start),
        .o_busy      (busy),
        .i_new_pass  (i_new_pass),
        .i_device    (i_device),
        .i_def_op    (i_def_op),
        .i_end_op    (i_end_op),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_mem_we    (w_mem_we),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata)
    );

    // Free-time store, one entry per slot of every device.
    lssa_slot_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (TIME_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

endmodule

>>> hw/rtl/lssa_checker.sv
// Port-level checker of the slot allocator, bound to the top level.
// Depends on lssa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lssa_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_done,
    input logic [lssa_pkg::STATUS_W-1:0]      o_status,
    input logic [lssa_pkg::SLOT_FIELD_W-1:0]  o_slot
);
    import lssa_pkg::*;

    // An accepted request keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // A result beat is shown only once the block is ready for the next request.
    `ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    // Each request gives one result beat, so beats never come back to back.
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)

    // A refused request reports slot zero.
    `ASSERT_IMPLY(a_refused_slot, i_clk, i_rst_n, o_done && (o_status != STAT_GRANT), o_slot == '0)

endmodule

bind linear_scan_slot_allocator lssa_checker u_lssa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_status (o_status),
    .o_slot   (o_slot)
);
